[src/box_filter_3x3_stream_core_defines.svh]
`ifndef BOX_FILTER_3X3_STREAM_CORE_DEFINES_SVH
`define BOX_FILTER_3X3_STREAM_CORE_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define BFS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("box filter: same-cycle check failed");

// Next-cycle implication, masked while reset is asserted.
`define BFS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("box filter: next-cycle check failed");

`endif

[src/bfs_pkg.sv]
package bfs_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 4095;
  localparam int MIN_SIZE   = 3;

  localparam int PIX_W  = 8;
  localparam int WREG_W = 10;
  localparam int HREG_W = 12;
  localparam int ROW_W  = HREG_W;
  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int COL_W  = $clog2(MAX_WIDTH + 1);

  // column sum of three pixels, window sum of nine
  localparam int CSUM_W = PIX_W + 2;
  localparam int SUM_W  = PIX_W + 4;

  // floor(sum / 9) == (sum * 7282) >> 16 for every sum up to 9 * 255
  localparam int DIV9_MUL   = 7282;
  localparam int DIV9_SHIFT = 16;
  localparam int MUL_W      = 13;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;
  localparam int REG_LSB = 2;

  localparam logic [WREG_W-1:0] WIDTH_RESET  = WREG_W'(512);
  localparam logic [HREG_W-1:0] HEIGHT_RESET = HREG_W'(512);

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_sel_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  // One classified beat, handed from the front to the back.
  typedef struct packed {
    logic              is_drain;
    logic [ADDR_W-1:0] addr;        // line store read/write column
    logic [PIX_W-1:0]  pix;
    logic              produce;     // beat yields a result
    logic              interior;    // result is the 3x3 mean
    logic              use_corner;  // result is the saved last-column pixel
    logic              corner_load; // beat is in the last column: save corner
    logic              last;        // final result of the frame
  } q_entry_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
  } q_stat_t;

  typedef struct packed {
    logic s1_valid;
    logic s2_valid;
  } back_stat_t;

endpackage

[src/bfs_ram.sv]
module bfs_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/bfs_front.sv]
module bfs_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [bfs_pkg::APB_AW-1:0]    cfg_paddr,
  input  logic [bfs_pkg::APB_DW-1:0]    cfg_pwdata,
  output logic [bfs_pkg::APB_DW-1:0]    cfg_prdata,
  input  logic                          in_valid,
  input  logic                          in_op,
  input  logic [bfs_pkg::PIX_W-1:0]     in_pix,
  output logic                          in_ready,
  input  logic                          q_full,
  output logic                          q_push,
  output bfs_pkg::q_entry_t             q_entry
);

  import bfs_pkg::*;

  logic [WREG_W-1:0] width_r, width_nxt;
  logic [HREG_W-1:0] height_r, height_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  used_w;
  logic [ROW_W-1:0]  used_h;
  logic              cfg_wr;
  reg_sel_t          cfg_sel;
  logic              accept;
  logic              is_drain;
  logic              restart;
  logic              drain_ok;
  logic [COL_W-1:0]  c;
  logic [COL_W-1:0]  c_inc;
  logic [ROW_W-1:0]  r;

  assign cfg_wr  = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_sel = reg_sel_t'(cfg_paddr[REG_LSB]);

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_wr) begin
      case (cfg_sel)
        REG_WIDTH:  width_nxt  = cfg_pwdata[WREG_W-1:0];
        REG_HEIGHT: height_nxt = cfg_pwdata[HREG_W-1:0];
        default:    width_nxt  = width_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_WIDTH:  cfg_prdata = APB_DW'(width_r);
      REG_HEIGHT: cfg_prdata = APB_DW'(height_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // clamp the registers to the supported frame size
  always_comb begin
    if (32'(width_r) < MIN_SIZE) begin
      used_w = COL_W'(MIN_SIZE);
    end else if (32'(width_r) > MAX_WIDTH) begin
      used_w = COL_W'(MAX_WIDTH);
    end else begin
      used_w = COL_W'(width_r);
    end
    if (32'(height_r) < MIN_SIZE) begin
      used_h = ROW_W'(MIN_SIZE);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      used_h = ROW_W'(MAX_HEIGHT);
    end else begin
      used_h = ROW_W'(height_r);
    end
  end

  assign in_ready = ~q_full;
  assign accept   = in_valid & in_ready;
  assign is_drain = (in_op == OP_DRAIN);
  assign restart  = (row_r >= used_h) || (col_r >= used_w);
  assign drain_ok = (row_r >= used_h) && (col_r <= used_w);
  assign r        = restart ? '0 : row_r;
  assign c        = restart ? '0 : col_r;
  assign c_inc    = c + 1'b1;
  assign q_push   = accept & (~is_drain | drain_ok);

  // classify the beat
  always_comb begin
    q_entry = '0;
    if (is_drain) begin
      q_entry.is_drain   = 1'b1;
      q_entry.addr       = ADDR_W'(col_r - 1'b1);
      q_entry.produce    = 1'b1;
      q_entry.use_corner = (col_r == '0);
      q_entry.last       = (col_r == used_w);
    end else begin
      q_entry.addr        = ADDR_W'(c);
      q_entry.pix         = in_pix;
      q_entry.produce     = (r >= ROW_W'(2)) || ((r != '0) && (c != '0));
      q_entry.interior    = (r >= ROW_W'(2)) && (c >= COL_W'(2));
      q_entry.use_corner  = (c == '0);
      q_entry.corner_load = (c_inc == used_w);
    end
  end

  // advance the raster position
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_wr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (is_drain) begin
        if (drain_ok) begin
          if (col_r == used_w) begin
            col_nxt = '0;
            row_nxt = '0;
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
      end else if (c_inc >= used_w) begin
        col_nxt = '0;
        row_nxt = r + 1'b1;
      end else begin
        col_nxt = c_inc;
        row_nxt = r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

endmodule

[src/bfs_queue.sv]
module bfs_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bfs_pkg::q_entry_t wr_entry,
  input  logic              pop,
  output logic              rd_valid,
  output bfs_pkg::q_entry_t rd_entry,
  output bfs_pkg::q_stat_t  stat
);

  import bfs_pkg::*;

  q_entry_t          slot_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt;
  logic [QPTR_W-1:0] rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign stat.count = cnt_r;
  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign rd_valid   = (cnt_r != '0);
  assign rd_entry   = slot_r[rp_r];
  assign do_push    = push & ~stat.full;
  assign do_pop     = pop & rd_valid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == QPTR_W'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == QPTR_W'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[src/bfs_back.sv]
module bfs_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  bfs_pkg::q_entry_t         q_entry,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [bfs_pkg::PIX_W-1:0] out_pix,
  output logic                      out_last,
  output bfs_pkg::back_stat_t       stat
);

  import bfs_pkg::*;

  logic                      s1_valid_r;
  q_entry_t                  s1_r;
  logic                      s2_valid_r;
  logic                      s2_interior_r;
  logic                      s2_last_r;
  logic [SUM_W-1:0]          s2_sum_r;
  logic [PIX_W-1:0]          s2_pass_r;
  logic                      out_valid_r;
  logic                      out_last_r;
  logic [PIX_W-1:0]          out_pix_r;
  logic [CSUM_W-1:0]         cs1_r;
  logic [CSUM_W-1:0]         cs2_r;
  logic [PIX_W-1:0]          mid2_r;
  logic [PIX_W-1:0]          corner_r;
  logic [PIX_W-1:0]          above2;
  logic [PIX_W-1:0]          above1;
  logic [CSUM_W-1:0]         col_sum;
  logic [SUM_W-1:0]          win_sum;
  logic [PIX_W-1:0]          sel_val;
  logic [SUM_W+MUL_W-1:0]    prod;
  logic [PIX_W-1:0]          quot;
  logic                      s3_free;
  logic                      s2_move;
  logic                      s2_free;
  logic                      s1_move;
  logic                      s1_free;
  logic                      line_wr;

  // stall chain, output side first
  assign s3_free = ~out_valid_r | out_ready;
  assign s2_move = s2_valid_r & s3_free;
  assign s2_free = ~s2_valid_r | s3_free;
  assign s1_move = s1_valid_r & s2_free;
  assign s1_free = ~s1_valid_r | s2_free;
  assign q_pop   = q_valid & s1_free;
  assign line_wr = s1_move & ~s1_r.is_drain;

  // two lines back and one line back; read on pop, written as the beat leaves S1
  bfs_ram #(
    .DATA_W (PIX_W),
    .DEPTH  (MAX_WIDTH)
  ) u_upper (
    .clk   (clk),
    .we    (line_wr),
    .waddr (s1_r.addr),
    .wdata (above1),
    .re    (q_pop),
    .raddr (q_entry.addr),
    .rdata (above2)
  );

  bfs_ram #(
    .DATA_W (PIX_W),
    .DEPTH  (MAX_WIDTH)
  ) u_lower (
    .clk   (clk),
    .we    (line_wr),
    .waddr (s1_r.addr),
    .wdata (s1_r.pix),
    .re    (q_pop),
    .raddr (q_entry.addr),
    .rdata (above1)
  );

  // the window is kept as two registered column sums plus the newest column's sum
  assign col_sum = CSUM_W'(above2) + CSUM_W'(above1) + CSUM_W'(s1_r.pix);
  assign win_sum = SUM_W'(cs1_r) + SUM_W'(cs2_r) + SUM_W'(col_sum);

  always_comb begin
    if (s1_r.use_corner) begin
      sel_val = corner_r;
    end else if (s1_r.is_drain) begin
      sel_val = above1;
    end else begin
      sel_val = mid2_r;
    end
  end

  assign prod = (SUM_W + MUL_W)'(s2_sum_r) * (SUM_W + MUL_W)'(DIV9_MUL);
  assign quot = prod[DIV9_SHIFT +: PIX_W];

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_r <= q_entry;
    end
    if (line_wr) begin
      cs1_r  <= cs2_r;
      cs2_r  <= col_sum;
      mid2_r <= above1;
      if (s1_r.corner_load) begin
        corner_r <= above1;
      end
    end
    if (s1_move) begin
      s2_interior_r <= s1_r.interior;
      s2_last_r     <= s1_r.last;
      s2_sum_r      <= win_sum;
      s2_pass_r     <= sel_val;
    end
    if (s2_move) begin
      out_pix_r  <= s2_interior_r ? quot : s2_pass_r;
      out_last_r <= s2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        s2_valid_r <= s1_r.produce;
      end else if (s2_move) begin
        s2_valid_r <= 1'b0;
      end
      if (s2_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pix       = out_pix_r;
  assign out_last      = out_last_r;
  assign stat.s1_valid = s1_valid_r;
  assign stat.s2_valid = s2_valid_r;

endmodule

[src/box_filter_3x3_stream_core.sv]
// 3x3 mean filter for a raster stream of 8-bit greyscale pixels. Send pixel
// beats (in_tuser = 0) in raster order; the filtered image leaves in raster
// order, one line plus one pixel behind: interior results are the floor of the
// 3x3 sum over 9, first and last rows and columns pass through unchanged. The
// first image_width+1 pixels of a frame give no result. After the last pixel,
// send image_width+1 drain beats (in_tuser = 1) to flush the last line; the
// final result carries out_tlast. Drain beats outside that phase are dropped,
// and a pixel beat during it drops the pending results and starts a new frame.
// The block takes one beat per clock unless its queue is full: each line store
// is a RAM with one read and one write port, read when a beat enters the back
// end and written as it leaves the next stage, so a new beat can follow every
// cycle. A result passes from the queue through the first stage and the sum
// stage to the output register. A four-entry queue separates the classifying
// front end from the filter pipeline; in_tready drops only when that queue is
// full, i.e. when out_tready has been low long enough to back it up. Writing
// image_width (byte address 0) or image_height (address 4) restarts the frame;
// write only while the block is idle. The line stores need no clearing after
// reset: an entry that a frame reads before writing it feeds no result.
`include "box_filter_3x3_stream_core_defines.svh"

module box_filter_3x3_stream_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [bfs_pkg::APB_AW-1:0]    cfg_paddr,
  input  logic [bfs_pkg::APB_DW-1:0]    cfg_pwdata,
  output logic [bfs_pkg::APB_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready,
  // input beats
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] pixel_in
  input  logic [0:0]                    in_tuser,   // [0] op: 0 pixel, 1 drain
  // result beats
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // [7:0] pixel_out
  output logic                          out_tlast   // frame_last
);

  import bfs_pkg::*;

  logic       q_push;
  q_entry_t   q_wr_entry;
  logic       q_pop;
  logic       q_valid;
  q_entry_t   q_rd_entry;
  q_stat_t    q_stat;
  back_stat_t b_stat;

  // never wait states on the register port
  assign cfg_pready = 1'b1;

  // front: registers, raster counters, beat classification
  bfs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .in_valid    (in_tvalid),
    .in_op       (in_tuser[0]),
    .in_pix      (in_tdata),
    .in_ready    (in_tready),
    .q_full      (q_stat.full),
    .q_push      (q_push),
    .q_entry     (q_wr_entry)
  );

  // decouple: absorbs output stalls so the front keeps taking beats
  bfs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_wr_entry),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_entry (q_rd_entry),
    .stat     (q_stat)
  );

  // back: line stores, window, divide by nine, output register
  bfs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (q_rd_entry),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pix   (out_tdata),
    .out_last  (out_tlast),
    .stat      (b_stat)
  );

  // A full queue means the back end is holding a beat in its first stage.
  `BFS_ASSERT_IMP(a_full_holds_s1, clk, rst_n, q_stat.full, b_stat.s1_valid)
  // A valid sum stage is followed by a valid output register in the next cycle.
  `BFS_ASSERT_NXT(a_s2_reaches_out, clk, rst_n, b_stat.s2_valid, out_tvalid)
  // An idle first stage takes a queued beat at once.
  `BFS_ASSERT_NXT(a_queue_feeds_s1, clk, rst_n,
                  (q_stat.count != '0) && !b_stat.s1_valid, b_stat.s1_valid)
  // Frame ends are separated by whole frames: never two last beats in a row.
  `BFS_ASSERT_NXT(a_last_isolated, clk, rst_n,
                  out_tvalid && out_tready && out_tlast, !(out_tvalid && out_tlast))

endmodule
